/* design/gmdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gmdw_pkg;

	// Host command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Cell codes as stored in the grid memory.
	localparam logic [2:0] CELL_OPEN  = 3'd0;
	localparam logic [2:0] CELL_WALL  = 3'd1;
	localparam logic [2:0] CELL_START = 3'd2;
	localparam logic [2:0] CELL_GOAL  = 3'd3;
	localparam logic [2:0] CELL_SEEN  = 3'd4;
	localparam logic [2:0] CELL_DEAD  = 3'd5;

	// Side of the maze in use after reset.
	localparam logic [6:0] SIDE_RESET = 7'd8;

	typedef enum logic [1:0] {
		DIR_N,
		DIR_E,
		DIR_S,
		DIR_W
	} dir_t;

	typedef enum logic [3:0] {
		ST_RESET_CLR,
		ST_IDLE,
		ST_SWEEP,
		ST_SWEEP_TAIL,
		ST_WALK_INIT,
		ST_PROBE,
		ST_CHECK,
		ST_STUCK,
		ST_POP_RD,
		ST_POP_WR,
		ST_FIN
	} state_t;

	// Source of the grid memory write.
	typedef enum logic [2:0] {
		W_NONE,
		W_HOST,
		W_CLR,
		W_SWEEP,
		W_SEEN,
		W_DEAD,
		W_POP
	} wsel_t;

	// Source of the grid memory read.
	typedef enum logic [1:0] {
		R_NONE,
		R_HOST,
		R_SWEEP,
		R_NBR
	} rsel_t;

	typedef struct packed {
		wsel_t wsel;
		rsel_t rsel;
		dir_t  dir;
		logic  walk_init;
		logic  walk_move;
		logic  pop_rd;
		logic  ld_out;
		logic  out_found;
		logic  out_read;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic sweep_last;
		logic nb_ok;
		logic enterable;
		logic is_goal;
		logic at_start;
		logic path_empty;
	} dp_stat_t;

	function automatic dir_t dir_next(input dir_t d);
		dir_t r;
		case (d)
			DIR_N: r = DIR_E;
			DIR_E: r = DIR_S;
			DIR_S: r = DIR_W;
			default: r = DIR_N;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/gmdw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module gmdw_dp import gmdw_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	input  wire logic [5:0] row,
	input  wire logic [5:0] col,
	input  wire logic [1:0] cell_in,
	input  wire ctrl_cmd_t  cmd_c,
	output dp_stat_t        stat,
	output logic            found,
	output logic [2:0]      cell_out
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_SIDE);
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int XW    = (SW > 7) ? SW : 7;

	logic [6:0]    grid_side_q;
	logic [XW-1:0] side_n;
	logic [5:0]    start_row_q;
	logic [5:0]    start_col_q;
	logic [CW-1:0] walk_r_q;
	logic [CW-1:0] walk_c_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic [AW-1:0] path_cnt_q;
	logic [AW-1:0] path_rd_q;
	logic          rd_ok_q;
	logic [2:0]    grid_rd_q;
	logic [2:0]    grid_mem [DEPTH];
	logic [AW-1:0] path_mem [DEPTH];

	logic          host_ok;
	logic [AW-1:0] host_addr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] nb_addr;
	logic [CW-1:0] nb_r;
	logic [CW-1:0] nb_c;
	logic          nb_exists;
	logic          nb_is_start;
	logic          gr_we;
	logic [AW-1:0] gr_waddr;
	logic [2:0]    gr_wdata;
	logic          gr_re;
	logic [AW-1:0] gr_raddr;
	logic          sweep_step;
	logic          push;

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] r, input logic [XW-1:0] c);
		return AW'(r) * AW'(MAX_SIDE) + AW'(c);
	endfunction

	// Side in use, clamped to the supported range.
	always_comb begin
		if (XW'(grid_side_q) < XW'(2)) begin
			side_n = XW'(2);
		end else if (XW'(grid_side_q) > XW'(MAX_SIDE)) begin
			side_n = XW'(MAX_SIDE);
		end else begin
			side_n = XW'(grid_side_q);
		end
	end

	// Host cell and current walker cell addresses.
	assign host_ok   = (XW'(row) < side_n) && (XW'(col) < side_n);
	assign host_addr = cell_addr(XW'(row), XW'(col));
	assign cur_addr  = cell_addr(XW'(walk_r_q), XW'(walk_c_q));

	// Neighbor of the walker in the direction under test.
	always_comb begin
		nb_r      = walk_r_q;
		nb_c      = walk_c_q;
		nb_exists = 1'b0;
		case (cmd_c.dir)
			DIR_N: begin
				nb_exists = (walk_r_q != '0);
				nb_r      = walk_r_q - CW'(1);
			end
			DIR_E: begin
				nb_exists = (XW'(walk_c_q) + XW'(1)) < side_n;
				nb_c      = walk_c_q + CW'(1);
			end
			DIR_S: begin
				nb_exists = (XW'(walk_r_q) + XW'(1)) < side_n;
				nb_r      = walk_r_q + CW'(1);
			end
			default: begin
				nb_exists = (walk_c_q != '0);
				nb_c      = walk_c_q - CW'(1);
			end
		endcase
	end

	assign nb_is_start = (XW'(nb_r) == XW'(start_row_q)) && (XW'(nb_c) == XW'(start_col_q));
	assign nb_addr     = cell_addr(XW'(nb_r), XW'(nb_c));

	// Status back to the controller.
	assign stat.start_ok   = (XW'(start_row_q) < side_n) && (XW'(start_col_q) < side_n);
	assign stat.sweep_last = (sweep_q == AW'(DEPTH - 1));
	assign stat.nb_ok      = nb_exists && !nb_is_start;
	assign stat.enterable  = (grid_rd_q == CELL_OPEN) || (grid_rd_q == CELL_GOAL);
	assign stat.is_goal    = (grid_rd_q == CELL_GOAL);
	assign stat.at_start   = (XW'(walk_r_q) == XW'(start_row_q)) &&
	                         (XW'(walk_c_q) == XW'(start_col_q));
	assign stat.path_empty = (path_cnt_q == '0);

	// Grid write port selection.
	always_comb begin
		gr_we    = 1'b0;
		gr_waddr = cur_addr;
		gr_wdata = CELL_OPEN;
		case (cmd_c.wsel)
			W_HOST: begin
				gr_we    = host_ok;
				gr_waddr = host_addr;
				gr_wdata = {1'b0, cell_in};
			end
			W_CLR: begin
				gr_we    = 1'b1;
				gr_waddr = sweep_q;
			end
			W_SWEEP: begin
				gr_we    = vld_s1 && (grid_rd_q >= CELL_SEEN);
				gr_waddr = addr_s1;
			end
			W_SEEN: begin
				gr_we    = 1'b1;
				gr_wdata = CELL_SEEN;
			end
			W_DEAD: begin
				gr_we    = 1'b1;
				gr_wdata = CELL_DEAD;
			end
			W_POP: begin
				gr_we    = 1'b1;
				gr_waddr = path_rd_q;
			end
			default: begin
				gr_we = 1'b0;
			end
		endcase
	end

	// Grid read port selection.
	always_comb begin
		gr_re    = 1'b1;
		gr_raddr = nb_addr;
		case (cmd_c.rsel)
			R_HOST:  gr_raddr = host_addr;
			R_SWEEP: gr_raddr = sweep_q;
			R_NBR:   gr_raddr = nb_addr;
			default: gr_re = 1'b0;
		endcase
	end

	assign sweep_step = (cmd_c.wsel == W_CLR) || (cmd_c.rsel == R_SWEEP);
	assign push       = (cmd_c.wsel == W_SEEN);

	// Grid memory with registered read data.
	always_ff @(posedge clk) begin
		if (gr_we) begin
			grid_mem[gr_waddr] <= gr_wdata;
		end
		if (gr_re) begin
			grid_rd_q <= grid_mem[gr_raddr];
		end
	end

	// Path memory: the cells marked visited on the current walk, in order.
	always_ff @(posedge clk) begin
		if (push) begin
			path_mem[path_cnt_q] <= cur_addr;
		end
		if (cmd_c.pop_rd) begin
			path_rd_q <= path_mem[path_cnt_q - AW'(1)];
		end
	end

	// Sweep pipeline stage: address of the entry whose read data is due.
	always_ff @(posedge clk) begin
		addr_s1 <= sweep_q;
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
			start_row_q <= '0;
			start_col_q <= '0;
			walk_r_q    <= '0;
			walk_c_q    <= '0;
			sweep_q     <= '0;
			vld_s1      <= 1'b0;
			path_cnt_q  <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				grid_side_q <= cfg_data;
			end
			if ((cmd_c.wsel == W_HOST) && host_ok && ({1'b0, cell_in} == CELL_START)) begin
				start_row_q <= row;
				start_col_q <= col;
			end
			if (cmd_c.walk_init) begin
				walk_r_q <= CW'(start_row_q);
				walk_c_q <= CW'(start_col_q);
			end else if (cmd_c.walk_move) begin
				walk_r_q <= nb_r;
				walk_c_q <= nb_c;
			end
			if (sweep_step) begin
				sweep_q <= stat.sweep_last ? '0 : sweep_q + AW'(1);
			end
			vld_s1 <= (cmd_c.rsel == R_SWEEP);
			if (cmd_c.walk_init) begin
				path_cnt_q <= '0;
			end else if (push) begin
				path_cnt_q <= path_cnt_q + AW'(1);
			end else if (cmd_c.pop_rd) begin
				path_cnt_q <= path_cnt_q - AW'(1);
			end
			if (cmd_c.rsel == R_HOST) begin
				rd_ok_q <= host_ok;
			end
		end
	end

	// Result register; visited cells read back as path, dead ends as open.
	always_ff @(posedge clk) begin
		if (cmd_c.ld_out) begin
			found <= cmd_c.out_found;
			if (cmd_c.out_read && rd_ok_q) begin
				cell_out <= (grid_rd_q <= CELL_SEEN) ? grid_rd_q : CELL_OPEN;
			end else begin
				cell_out <= CELL_OPEN;
			end
		end
	end

endmodule

`default_nettype wire

/* design/gmdw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gmdw_ctrl import gmdw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_stat_t   stat,
	output ctrl_cmd_t       cmd_c
);

	state_t state_q;
	state_t state_d;
	dir_t   dir_q;
	dir_t   dir_d;
	logic   res_found_q;
	logic   res_found_d;
	logic   res_read_q;
	logic   res_read_d;
	logic   out_valid_q;

	// State and result-kind registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RESET_CLR;
			dir_q       <= DIR_N;
			res_found_q <= 1'b0;
			res_read_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			dir_q       <= dir_d;
			res_found_q <= res_found_d;
			res_read_q  <= res_read_d;
			if (cmd_c.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		dir_d           = dir_q;
		res_found_d     = res_found_q;
		res_read_d      = res_read_q;
		in_ready        = 1'b0;
		cmd_c           = '0;
		cmd_c.wsel      = W_NONE;
		cmd_c.rsel      = R_NONE;
		cmd_c.dir       = dir_q;
		cmd_c.out_found = res_found_q;
		cmd_c.out_read  = res_read_q;
		case (state_q)
			ST_RESET_CLR: begin
				cmd_c.wsel = W_CLR;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_found_d = 1'b0;
					res_read_d  = 1'b0;
					state_d     = ST_FIN;
					case (cmd)
						CMD_WRITE: begin
							cmd_c.wsel = W_HOST;
						end
						CMD_READ: begin
							cmd_c.rsel = R_HOST;
							res_read_d = 1'b1;
						end
						CMD_SOLVE: begin
							if (stat.start_ok) begin
								state_d = ST_SWEEP;
							end
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				cmd_c.rsel = R_SWEEP;
				cmd_c.wsel = W_SWEEP;
				if (stat.sweep_last) begin
					state_d = ST_SWEEP_TAIL;
				end
			end
			ST_SWEEP_TAIL: begin
				cmd_c.wsel = W_SWEEP;
				state_d    = ST_WALK_INIT;
			end
			ST_WALK_INIT: begin
				cmd_c.walk_init = 1'b1;
				dir_d           = DIR_N;
				state_d         = ST_PROBE;
			end
			ST_PROBE: begin
				if (stat.nb_ok) begin
					cmd_c.rsel = R_NBR;
					state_d    = ST_CHECK;
				end else if (dir_q == DIR_W) begin
					state_d = ST_STUCK;
				end else begin
					dir_d = dir_next(dir_q);
				end
			end
			ST_CHECK: begin
				if (stat.enterable) begin
					if (!stat.at_start) begin
						cmd_c.wsel = W_SEEN;
					end
					if (stat.is_goal) begin
						res_found_d = 1'b1;
						state_d     = ST_FIN;
					end else begin
						cmd_c.walk_move = 1'b1;
						dir_d           = DIR_N;
						state_d         = ST_PROBE;
					end
				end else if (dir_q == DIR_W) begin
					state_d = ST_STUCK;
				end else begin
					dir_d   = dir_next(dir_q);
					state_d = ST_PROBE;
				end
			end
			ST_STUCK: begin
				if (stat.at_start) begin
					state_d = ST_FIN;
				end else begin
					cmd_c.wsel = W_DEAD;
					state_d    = stat.path_empty ? ST_WALK_INIT : ST_POP_RD;
				end
			end
			ST_POP_RD: begin
				cmd_c.pop_rd = 1'b1;
				state_d      = ST_POP_WR;
			end
			ST_POP_WR: begin
				cmd_c.wsel = W_POP;
				state_d    = stat.path_empty ? ST_WALK_INIT : ST_POP_RD;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd_c.ld_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.ld_out |-> (!out_valid_q || out_ready))
		else $error("result loaded while the previous beat is still pending");

	// A new result appears only out of the finish state.
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output valid rose outside the finish state");

	// A neighbor check always follows a probe that issued the read.
	a_check_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> $past((state_q == ST_PROBE) && stat.nb_ok))
		else $error("neighbor check without a preceding read");

	// The path list is never popped when it is empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_RD) |-> !stat.path_empty)
		else $error("path list popped while empty");

endmodule

`default_nettype wire

/* design/grid_maze_dead_end_walker_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Maze walker with dead-end elimination over a square grid of up to MAX_SIDE x MAX_SIDE
// cells held in an on-chip memory. After reset the block clears all MAX_SIDE*MAX_SIDE
// cells (4096 at the default) to open, one cell a cycle, and takes no item meanwhile.
// A cell write or read is accepted in the idle state and loads its result from the
// finish state. A solve whose start lies inside the grid first sweeps the whole grid to
// drop old visited and dead-end marks, then starts the walk. Each direction tried takes
// a neighbor read, then a check, or the probe alone when the neighbor is off the grid or
// is the start. A dead end is marked, each visited cell unwound on a restart is read from
// the path list and then reopened, and the walk restarts. The result is loaded into the
// output register once the walk ends. Solve time is thus set by the single grid read port
// and depends on the maze. One result beat is returned per item; a finished result waits
// in the output register, and the following item stalls in its finish state until it is taken.

module grid_maze_dead_end_walker_top import gmdw_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [5:0] row,
	input  wire logic [5:0] col,
	input  wire logic [1:0] cell_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            found,
	output logic [2:0]      cell_out
);

	ctrl_cmd_t cmd_c;
	dp_stat_t  stat;

	// Controller: sequences host commands, the sweeps and the walk.
	gmdw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd_c     (cmd_c)
	);

	// Datapath: grid and path memories, walker position and result register.
	gmdw_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.row      (row),
		.col      (col),
		.cell_in  (cell_in),
		.cmd_c    (cmd_c),
		.stat     (stat),
		.found    (found),
		.cell_out (cell_out)
	);

endmodule

`default_nettype wire

/* tb/gmdw_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the side register of the maze walker, keeps its own
// copy of the maze, and checks every result beat against the oldest reply owed.
module gmdw_checker import gmdw_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [5:0] row,
	input  logic [5:0] col,
	input  logic [1:0] cell_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       found,
	input  logic [2:0] cell_out,
	output int         mismatches,
	output int         replies_owed
);

	typedef struct packed {
		logic       found;
		logic [2:0] cell_code;
	} maze_reply_t;

	// Shadow of the maze and its registers.
	logic [2:0]  maze [MAX_SIDE * MAX_SIDE];
	logic [5:0]  home_row;
	logic [5:0]  home_col;
	logic [6:0]  side_reg;
	maze_reply_t replies_due[$];
	int          errs;

	function automatic int eff_side();
		int s;
		s = side_reg;
		if (s < 2) begin
			s = 2;
		end
		if (s > MAX_SIDE) begin
			s = MAX_SIDE;
		end
		return s;
	endfunction

	function automatic int cell_at(input int r, input int c);
		return r * MAX_SIDE + c;
	endfunction

	// The walker may step onto open or goal cells, but never back onto the start.
	function automatic logic open_to_walk(input int r, input int c);
		logic [2:0] v;
		if (r == home_row && c == home_col) begin
			return 1'b0;
		end
		v = maze[cell_at(r, c)];
		return v == CELL_OPEN || v == CELL_GOAL;
	endfunction

	// Greedy walk with dead-end elimination; returns 1 when the goal is reached.
	function automatic logic walk_maze();
		int n, r, c, nr, nc, k;
		int trail[$];
		n = eff_side();
		if (home_row >= n || home_col >= n) begin
			return 1'b0;
		end
		for (k = 0; k < MAX_SIDE * MAX_SIDE; k++) begin
			if (maze[k] == CELL_SEEN || maze[k] == CELL_DEAD) begin
				maze[k] = CELL_OPEN;
			end
		end
		while (1'b1) begin
			r = home_row;
			c = home_col;
			trail.delete();
			while (1'b1) begin
				if (r > 0 && open_to_walk(r - 1, c)) begin
					nr = r - 1;
					nc = c;
				end else if (c + 1 < n && open_to_walk(r, c + 1)) begin
					nr = r;
					nc = c + 1;
				end else if (r + 1 < n && open_to_walk(r + 1, c)) begin
					nr = r + 1;
					nc = c;
				end else if (c > 0 && open_to_walk(r, c - 1)) begin
					nr = r;
					nc = c - 1;
				end else begin
					// Stuck: a stuck start means no path, otherwise retire this cell.
					if (r == home_row && c == home_col) begin
						return 1'b0;
					end
					maze[cell_at(r, c)] = CELL_DEAD;
					foreach (trail[i]) begin
						maze[trail[i]] = CELL_OPEN;
					end
					break;
				end
				if (!(r == home_row && c == home_col)) begin
					maze[cell_at(r, c)] = CELL_SEEN;
					trail.push_back(cell_at(r, c));
				end
				if (maze[cell_at(nr, nc)] == CELL_GOAL) begin
					return 1'b1;
				end
				r = nr;
				c = nc;
			end
		end
		return 1'b0;
	endfunction

	// Applies one accepted item to the shadow maze and works out its reply.
	function automatic maze_reply_t predict_reply(input logic [1:0] op, input logic [5:0] r,
			input logic [5:0] c, input logic [1:0] v);
		maze_reply_t rep;
		logic [2:0]  g;
		int          n;
		rep.found = 1'b0;
		rep.cell_code = CELL_OPEN;
		n = eff_side();
		case (op)
			CMD_WRITE: begin
				if (r < n && c < n) begin
					maze[cell_at(r, c)] = {1'b0, v};
					if ({1'b0, v} == CELL_START) begin
						home_row = r;
						home_col = c;
					end
				end
			end
			CMD_SOLVE: begin
				rep.found = walk_maze();
			end
			CMD_READ: begin
				if (r < n && c < n) begin
					g = maze[cell_at(r, c)];
					rep.cell_code = (g <= CELL_SEEN) ? g : CELL_OPEN;
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		maze_reply_t due;
		if (!arst_n) begin
			foreach (maze[k]) begin
				maze[k] = CELL_OPEN;
			end
			home_row = '0;
			home_col = '0;
			side_reg = SIDE_RESET;
			replies_due.delete();
			errs = 0;
			mismatches <= 0;
			replies_owed <= 0;
		end else begin
			if (cfg_we) begin
				side_reg = cfg_data;
			end
			// Compare a result beat before queuing a reply for an item taken at this edge.
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result beat with nothing outstanding: found %0d, cell_out %0d",
						found, cell_out);
					errs++;
				end else begin
					due = replies_due.pop_front();
					if (found !== due.found) begin
						$error("found mismatch: expected %0d, got %0d", due.found, found);
						errs++;
					end
					if (cell_out !== due.cell_code) begin
						$error("cell_out mismatch: expected %0d, got %0d", due.cell_code,
							cell_out);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				replies_due.push_back(predict_reply(cmd, row, col, cell_in));
			end
			mismatches <= errs;
			replies_owed <= replies_due.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import gmdw_pkg::*;

	localparam int         MAX_SIDE = 64;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] cmd = '0;
	logic [5:0] row = '0;
	logic [5:0] col = '0;
	logic [1:0] cell_in = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       found;
	logic [2:0] cell_out;
	int         mismatches;
	int         replies_owed;

	// Stimulus bookkeeping.
	int side_eff = 8;
	int sent_work = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;

	grid_maze_dead_end_walker_top #(
		.MAX_SIDE(MAX_SIDE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row(row),
		.col(col),
		.cell_in(cell_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.cell_out(cell_out)
	);

	gmdw_checker #(
		.MAX_SIDE(MAX_SIDE)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row(row),
		.col(col),
		.cell_in(cell_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.cell_out(cell_out),
		.mismatches(mismatches),
		.replies_owed(replies_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// Mostly open and wall cells, with the odd goal or start.
	function automatic logic [2:0] pick_cell();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			return CELL_OPEN;
		end else if (k < 85) begin
			return CELL_WALL;
		end else if (k < 93) begin
			return CELL_GOAL;
		end
		return CELL_START;
	endfunction

	// Presents one item after a random gap and waits until it is accepted.
	task automatic send_item(input logic [1:0] op, input int r, input int c,
			input logic [2:0] code);
		int gap;
		gap = draw_gap(quiet_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		row <= 6'(r);
		col <= 6'(c);
		cell_in <= code[1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op != CMD_NOP) begin
			sent_work++;
		end
	endtask

	// Drops valid and waits until every reply owed has come back.
	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
	endtask

	task automatic set_side(input logic [6:0] v);
		go_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		side_eff = (v < 2) ? 2 : (v > MAX_SIDE) ? MAX_SIDE : v;
	endtask

	// Result side: a fresh stall before each beat.
	initial begin : result_side
		int stall;
		@(posedge clk);
		forever begin
			stall = draw_gap(quiet_out);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int kind, n, r, c, d, k, reps;
		int dr[4];
		int dc[4];
		dr = '{-1, 0, 1, 0};
		dc = '{0, 1, 0, -1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset side of 8: fresh grid, no-op with all ones, out-of-range access, easy solve.
		send_item(CMD_READ, 0, 0, CELL_OPEN);
		send_item(CMD_NOP, 63, 63, CELL_GOAL);
		send_item(CMD_WRITE, 7, 7, CELL_GOAL);
		send_item(CMD_WRITE, 8, 0, CELL_WALL);
		send_item(CMD_READ, 8, 0, CELL_OPEN);
		send_item(CMD_SOLVE, 0, 0, CELL_OPEN);
		send_item(CMD_READ, 0, 1, CELL_OPEN);
		send_item(CMD_READ, 0, 0, CELL_OPEN);

		// Side register zero clamps to two: a dead end, then a path once a goal appears.
		set_side(7'd0);
		send_item(CMD_WRITE, 0, 0, CELL_START);
		send_item(CMD_WRITE, 0, 1, CELL_OPEN);
		send_item(CMD_WRITE, 1, 0, CELL_WALL);
		send_item(CMD_WRITE, 1, 1, CELL_WALL);
		send_item(CMD_SOLVE, 0, 0, CELL_OPEN);
		send_item(CMD_READ, 0, 1, CELL_OPEN);
		send_item(CMD_WRITE, 1, 1, CELL_GOAL);
		send_item(CMD_SOLVE, 63, 63, CELL_GOAL);
		send_item(CMD_READ, 0, 1, CELL_OPEN);
		send_item(CMD_READ, 1, 1, CELL_OPEN);
		send_item(CMD_READ, 1, 0, CELL_OPEN);
		send_item(CMD_READ, 0, 0, CELL_OPEN);

		// A start placed at the far corner and then left outside a shrunken maze.
		set_side(7'd127);
		send_item(CMD_WRITE, 63, 63, CELL_START);
		set_side(7'd1);
		send_item(CMD_SOLVE, 0, 0, CELL_OPEN);
		send_item(CMD_READ, 63, 63, CELL_OPEN);

		// Random mazes, each loaded, solved and read back under a fresh side.
		while (sent_work < 380) begin
			kind = $urandom_range(0, 9);
			quiet_in = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			if (kind == 9) begin
				set_side(7'($urandom_range(64, 127)));
			end else if (kind >= 7) begin
				set_side(7'($urandom_range(7, 8)));
			end else if (kind == 0) begin
				set_side(7'($urandom_range(0, 1)));
			end else begin
				set_side(7'($urandom_range(2, 6)));
			end
			n = side_eff;

			if (kind == 9) begin
				// Full-size maze: scattered writes, then a start with its goal one step away in a random
				// direction, every earlier direction walled off, or with all four directions walled off.
				repeat ($urandom_range(3, 8)) begin
					send_item(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
						pick_cell());
				end
				r = $urandom_range(1, 62);
				c = $urandom_range(1, 62);
				send_item(CMD_WRITE, r, c, CELL_START);
				d = $urandom_range(0, 4);
				for (k = 0; k < 4 && k <= d; k++) begin
					send_item(CMD_WRITE, r + dr[k], c + dc[k], (k < d) ? CELL_WALL : CELL_GOAL);
				end
				send_item(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), pick_cell());
				for (k = 0; k < 4; k++) begin
					send_item(CMD_READ, r + dr[k], c + dc[k], pick_cell());
				end
				repeat ($urandom_range(2, 5)) begin
					send_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
						pick_cell());
				end
			end else begin
				// Small maze with random content and a little noise mixed in.
				reps = $urandom_range(n, n * n);
				if (reps > 40) begin
					reps = 40;
				end
				repeat (reps) begin
					k = $urandom_range(0, 19);
					if (k == 0) begin
						send_item(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
							pick_cell());
					end else if (k == 1) begin
						send_item(CMD_WRITE, $urandom_range(n, 63), $urandom_range(0, 63),
							pick_cell());
					end else if (k == 2) begin
						send_item(CMD_WRITE, $urandom_range(0, 63), $urandom_range(n, 63),
							pick_cell());
					end else begin
						send_item(CMD_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
							pick_cell());
					end
				end
				// Now and then the solve runs without a fresh start and goal.
				if ($urandom_range(0, 6) != 0) begin
					send_item(CMD_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						CELL_START);
					send_item(CMD_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						CELL_GOAL);
				end
				repeat ($urandom_range(1, 2)) begin
					send_item(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
						pick_cell());
					repeat ($urandom_range(2, 8)) begin
						if ($urandom_range(0, 6) == 0) begin
							send_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
								pick_cell());
						end else begin
							send_item(CMD_READ, $urandom_range(0, n - 1),
								$urandom_range(0, n - 1), pick_cell());
						end
					end
					if ($urandom_range(0, 2) == 0) begin
						send_item(CMD_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
							pick_cell());
					end
				end
			end
		end

		// Let the last replies drain, then keep watching for any stray beat before the verdict.
		go_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && replies_owed == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legitimate run.
	initial begin : watchdog
		#40_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
